[hw/rtl/irc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// irc_pkg
// Shared types and constants of the IR edge capture and carrier estimator.
// ----------------------------------------------------------------------------
package irc_pkg;

    localparam int TS_W        = 48;
    localparam int WID_W       = 31;
    localparam int EIDX_W      = 9;
    localparam int CNT_W       = 16;
    localparam int FREQ_W      = 32;
    localparam int DBC_W       = 16;
    localparam int DVD_W       = 36;
    localparam int DIV_STEPS   = DVD_W;
    localparam int DCNT_W      = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [DBC_W-1:0] DBC_RESET    = 16'd100;
    localparam logic [19:0]      USEC_PER_SEC = 20'd1000000;
    localparam logic [WID_W-1:0] WID_MAX      = '1;
    localparam logic [CNT_W-1:0] CNT_MAX      = '1;
    localparam logic [FREQ_W-1:0] FREQ_MAX    = '1;

    typedef enum logic [1:0] {
        PH_RESET = 2'd0,
        PH_IDLE  = 2'd1,
        PH_BURST = 2'd2,
        PH_RAW   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_MUL  = 2'd1,
        BK_DIV  = 2'd2,
        BK_EMIT = 2'd3
    } t_bk_state;

    typedef struct packed {
        logic              mark;
        logic [WID_W-1:0]  width_us;
        logic [EIDX_W-1:0] index;
    } t_entry;

    // one request from the classifier to the back end
    typedef struct packed {
        logic              clear;
        logic [1:0]        n_ent;
        t_entry [1:0]      ent;
        logic              div_req;
        logic [CNT_W-1:0]  pcnt;
        logic [TS_W-1:0]   dur;
    } t_job;

endpackage
`default_nettype wire

[hw/rtl/irc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// irc_front
// Edge classifier: phase machine, entry numbering and debounce register.
// Emits one request per accepted item that yields entries, ends a raw burst
// or is a clear.
// ----------------------------------------------------------------------------
module irc_front #(
    parameter int BUF_ENTRIES = 512
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic                        i_mode,
    input  wire logic [irc_pkg::TS_W-1:0]    i_time_us,
    input  wire logic                        i_rising,
    input  wire logic                        i_falling,
    input  wire logic                        i_cfg_we,
    input  wire logic [irc_pkg::DBC_W-1:0]   i_cfg_debounce_us,
    output irc_pkg::t_job                    o_job,
    output logic                             o_job_push
);

    localparam int IDX_W = $clog2(BUF_ENTRIES + 1);
    localparam logic [IDX_W-1:0] BUF_LIMIT = IDX_W'(BUF_ENTRIES);

    irc_pkg::t_phase               r_phase, n_phase;
    logic [irc_pkg::TS_W-1:0]      r_last, n_last;
    logic [irc_pkg::TS_W-1:0]      r_bstart, n_bstart;
    logic [irc_pkg::CNT_W-1:0]     r_pcnt, n_pcnt;
    logic [IDX_W-1:0]              r_idx, n_idx;
    logic [irc_pkg::DBC_W-1:0]     r_debounce;

    function automatic irc_pkg::t_entry mk_entry(input logic mark,
                                                 input logic [irc_pkg::TS_W-1:0] dur,
                                                 input logic [IDX_W-1:0] idx);
        irc_pkg::t_entry e;
        logic [irc_pkg::EIDX_W+IDX_W-1:0] idx_ext;
        idx_ext    = {{irc_pkg::EIDX_W{1'b0}}, idx};
        e.mark     = mark;
        e.width_us = (dur > irc_pkg::TS_W'(irc_pkg::WID_MAX)) ? irc_pkg::WID_MAX
                                                              : dur[irc_pkg::WID_W-1:0];
        e.index    = idx_ext[irc_pkg::EIDX_W-1:0];
        return e;
    endfunction

    always_comb begin
        logic [irc_pkg::TS_W-1:0] gap;
        logic [irc_pkg::TS_W-1:0] raw_dur;
        logic [irc_pkg::TS_W-1:0] deb;
        irc_pkg::t_phase          cur;
        irc_pkg::t_job            job;
        logic                     push;

        n_phase  = r_phase;
        n_last   = r_last;
        n_bstart = r_bstart;
        n_pcnt   = r_pcnt;
        n_idx    = r_idx;
        job      = '0;
        push     = 1'b0;
        gap      = i_time_us - r_last;
        raw_dur  = r_last - r_bstart;
        deb      = {{(irc_pkg::TS_W-irc_pkg::DBC_W){1'b0}}, r_debounce};
        cur      = r_phase;

        if (i_accept) begin
            if (i_mode) begin
                n_phase   = irc_pkg::PH_RESET;
                n_last    = '0;
                n_bstart  = '0;
                n_pcnt    = '0;
                n_idx     = '0;
                job.clear = 1'b1;
                push      = 1'b1;
            end else begin
                if (r_phase == irc_pkg::PH_RAW && gap > deb) begin
                    if (n_idx < BUF_LIMIT) begin
                        job.ent[job.n_ent[0]] = mk_entry(1'b1, raw_dur, n_idx);
                        job.n_ent = job.n_ent + 2'd1;
                        n_idx     = n_idx + 1'b1;
                    end
                    job.div_req = 1'b1;
                    job.pcnt    = r_pcnt;
                    job.dur     = raw_dur;
                    n_pcnt      = '0;
                    n_phase     = irc_pkg::PH_IDLE;
                end
                n_last = i_time_us;
                if (n_phase == irc_pkg::PH_RESET) begin
                    n_phase = irc_pkg::PH_IDLE;
                    gap     = '0;
                end
                cur = n_phase;
                unique case (cur)
                    irc_pkg::PH_IDLE: begin
                        if (i_falling) begin
                            if (gap != '0 && n_idx < BUF_LIMIT) begin
                                job.ent[job.n_ent[0]] = mk_entry(1'b0, gap, n_idx);
                                job.n_ent = job.n_ent + 2'd1;
                                n_idx     = n_idx + 1'b1;
                            end
                            n_phase  = irc_pkg::PH_BURST;
                            n_bstart = i_time_us;
                        end
                    end
                    irc_pkg::PH_BURST: begin
                        if (r_debounce != '0 && gap <= deb) begin
                            n_phase = irc_pkg::PH_RAW;
                            if (i_rising && n_pcnt != irc_pkg::CNT_MAX) begin
                                n_pcnt = n_pcnt + 1'b1;
                            end
                        end else if (i_rising) begin
                            if (n_idx < BUF_LIMIT) begin
                                job.ent[job.n_ent[0]] = mk_entry(1'b1, gap, n_idx);
                                job.n_ent = job.n_ent + 2'd1;
                                n_idx     = n_idx + 1'b1;
                            end
                            n_phase = irc_pkg::PH_IDLE;
                            n_pcnt  = '0;
                        end
                    end
                    irc_pkg::PH_RAW: begin
                        if (i_rising && n_pcnt != irc_pkg::CNT_MAX) begin
                            n_pcnt = n_pcnt + 1'b1;
                        end
                    end
                    default: begin
                        n_phase = irc_pkg::PH_IDLE;
                    end
                endcase
                push = job.div_req || (job.n_ent != 2'd0);
            end
        end
        o_job      = job;
        o_job_push = push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= irc_pkg::PH_RESET;
            r_last     <= '0;
            r_bstart   <= '0;
            r_pcnt     <= '0;
            r_idx      <= '0;
            r_debounce <= irc_pkg::DBC_RESET;
        end else begin
            r_phase  <= n_phase;
            r_last   <= n_last;
            r_bstart <= n_bstart;
            r_pcnt   <= n_pcnt;
            r_idx    <= n_idx;
            if (i_cfg_we) begin
                r_debounce <= i_cfg_debounce_us;
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/irc_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// irc_fifo
// Short request queue between classifier and back end.
// ----------------------------------------------------------------------------
module irc_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire irc_pkg::t_job  i_data,
    input  wire logic           i_pop,
    output irc_pkg::t_job       o_data,
    output logic                o_full,
    output logic                o_empty
);

    irc_pkg::t_job                r_mem [irc_pkg::QUEUE_DEPTH];
    logic [irc_pkg::QPTR_W-1:0]   r_wptr;
    logic [irc_pkg::QPTR_W-1:0]   r_rptr;
    logic [irc_pkg::QPTR_W:0]     r_count;

    assign o_full  = (r_count == (irc_pkg::QPTR_W+1)'(irc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if ((i_push && !o_full) && !(i_pop && !o_empty)) begin
                r_count <= r_count + 1'b1;
            end else if (!(i_push && !o_full) && (i_pop && !o_empty)) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/irc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// irc_back
// Back end: carrier estimate (multiply then restoring divide, one quotient
// bit per cycle) and delivery of the entries of each request.
// ----------------------------------------------------------------------------
module irc_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire irc_pkg::t_job                 i_job,
    input  wire logic                          i_job_empty,
    output logic                               o_job_pop,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic                               o_entry_is_burst,
    output logic [irc_pkg::WID_W-1:0]          o_entry_width_us,
    output logic [irc_pkg::EIDX_W-1:0]         o_entry_index,
    output logic [irc_pkg::FREQ_W-1:0]         o_carrier_freq_hz,
    output logic                               o_carrier_valid,
    output logic                               o_last_entry
);

    localparam logic [irc_pkg::DCNT_W-1:0] DIV_LAST = irc_pkg::DCNT_W'(irc_pkg::DIV_STEPS - 1);

    irc_pkg::t_bk_state              r_state, n_state;
    irc_pkg::t_job                   r_job;
    logic [irc_pkg::CNT_W-1:0]       r_best;
    logic [irc_pkg::FREQ_W-1:0]      r_freq;
    logic                            r_known;
    logic [irc_pkg::DVD_W-1:0]       r_dvd;
    logic [irc_pkg::TS_W-1:0]        r_rem;
    logic [irc_pkg::DCNT_W-1:0]      r_cnt;
    logic                            r_k;

    logic [irc_pkg::DVD_W-1:0]       mul_full;
    logic [irc_pkg::TS_W:0]          rem_sh;
    logic [irc_pkg::TS_W:0]          rem_sub;
    logic                            q_bit;
    logic [irc_pkg::DVD_W-1:0]       quo_nx;
    logic [irc_pkg::FREQ_W-1:0]      freq_sat;
    logic                            do_div;
    logic                            last_k;
    irc_pkg::t_entry                 cur_ent;

    assign mul_full = irc_pkg::DVD_W'(r_job.pcnt) * irc_pkg::DVD_W'(irc_pkg::USEC_PER_SEC);
    assign rem_sh   = {r_rem, r_dvd[irc_pkg::DVD_W-1]};
    assign rem_sub  = rem_sh - {1'b0, r_job.dur};
    assign q_bit    = (rem_sh >= {1'b0, r_job.dur});
    assign quo_nx   = {r_dvd[irc_pkg::DVD_W-2:0], q_bit};
    assign freq_sat = (quo_nx[irc_pkg::DVD_W-1:irc_pkg::FREQ_W] != '0) ? irc_pkg::FREQ_MAX
                                                                        : quo_nx[irc_pkg::FREQ_W-1:0];
    assign do_div   = i_job.div_req && (i_job.pcnt > r_best) && (i_job.dur != '0);
    assign last_k   = ({1'b0, r_k} == (r_job.n_ent - 2'd1));
    assign cur_ent  = r_job.ent[r_k];

    assign o_empty           = (r_state != irc_pkg::BK_EMIT);
    assign o_entry_is_burst  = cur_ent.mark;
    assign o_entry_width_us  = cur_ent.width_us;
    assign o_entry_index     = cur_ent.index;
    assign o_carrier_freq_hz = r_freq;
    assign o_carrier_valid   = r_known;
    assign o_last_entry      = last_k;

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        unique case (r_state)
            irc_pkg::BK_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    if (i_job.clear) begin
                        n_state = irc_pkg::BK_IDLE;
                    end else if (do_div) begin
                        n_state = irc_pkg::BK_MUL;
                    end else if (i_job.n_ent != 2'd0) begin
                        n_state = irc_pkg::BK_EMIT;
                    end
                end
            end
            irc_pkg::BK_MUL: begin
                n_state = irc_pkg::BK_DIV;
            end
            irc_pkg::BK_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = (r_job.n_ent != 2'd0) ? irc_pkg::BK_EMIT : irc_pkg::BK_IDLE;
                end
            end
            irc_pkg::BK_EMIT: begin
                if (i_pop && last_k) begin
                    n_state = irc_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = irc_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= irc_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best  <= '0;
            r_freq  <= '0;
            r_known <= 1'b0;
            r_cnt   <= '0;
            r_k     <= 1'b0;
        end else begin
            if (o_job_pop) begin
                r_k <= 1'b0;
                if (i_job.clear) begin
                    r_best  <= '0;
                    r_freq  <= '0;
                    r_known <= 1'b0;
                end
            end
            if (r_state == irc_pkg::BK_MUL) begin
                r_cnt <= '0;
            end
            if (r_state == irc_pkg::BK_DIV) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    r_freq  <= freq_sat;
                    r_known <= 1'b1;
                    r_best  <= r_job.pcnt;
                end
            end
            if (r_state == irc_pkg::BK_EMIT && i_pop && !last_k) begin
                r_k <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (r_state == irc_pkg::BK_MUL) begin
            r_dvd <= mul_full;
            r_rem <= '0;
        end else if (r_state == irc_pkg::BK_DIV) begin
            r_dvd <= quo_nx;
            r_rem <= q_bit ? rem_sub[irc_pkg::TS_W-1:0] : rem_sh[irc_pkg::TS_W-1:0];
        end
    end

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == irc_pkg::BK_EMIT) |-> ({1'b0, r_k} < r_job.n_ent))
        else $error("entry slot beyond request entry count");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == irc_pkg::BK_DIV) |-> (r_cnt <= DIV_LAST))
        else $error("divider step count out of range");

    a_known_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_known && !(o_job_pop && i_job.clear)) |=> r_known)
        else $error("carrier estimate lost without clear");

    a_div_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == irc_pkg::BK_MUL) |-> (r_job.dur != '0 && r_job.pcnt > r_best))
        else $error("divide started for a non-improving burst");

endmodule
`default_nettype wire

[hw/rtl/ir_edge_capture_carrier_estimator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ir_edge_capture_carrier_estimator_top
// IR mark/space capture with carrier frequency estimation.
// ----------------------------------------------------------------------------
// The classifier takes one edge or clear request per cycle while the 4-deep
// request queue has room, and logs up to BUF_ENTRIES entries. In the back end
// a request leaves the queue and its entries then go out one per cycle while
// pop is held. A request that ends a raw carrier burst of nonzero length with
// more pulses than any earlier one since the last clear runs a multiply step
// and 36 restoring divider steps, one quotient bit each, before its entries.
// The debounce register accepts a write every cycle.
module ir_edge_capture_carrier_estimator_top #(
    parameter int BUF_ENTRIES = 512
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_mode,
    input  wire logic [irc_pkg::TS_W-1:0]      i_time_us,
    input  wire logic                          i_rising,
    input  wire logic                          i_falling,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               o_entry_is_burst,
    output logic [irc_pkg::WID_W-1:0]          o_entry_width_us,
    output logic [irc_pkg::EIDX_W-1:0]         o_entry_index,
    output logic [irc_pkg::FREQ_W-1:0]         o_carrier_freq_hz,
    output logic                               o_carrier_valid,
    output logic                               o_last_entry,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [irc_pkg::DBC_W-1:0]     i_cfg_debounce_us
);

    irc_pkg::t_job  fe_job;
    logic           fe_push;
    irc_pkg::t_job  q_job;
    logic           q_empty;
    logic           bk_pop;
    logic           accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    irc_front #(
        .BUF_ENTRIES (BUF_ENTRIES)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_mode            (i_mode),
        .i_time_us         (i_time_us),
        .i_rising          (i_rising),
        .i_falling         (i_falling),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_debounce_us (i_cfg_debounce_us),
        .o_job             (fe_job),
        .o_job_push        (fe_push)
    );

    irc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  (fe_job),
        .i_pop   (bk_pop),
        .o_data  (q_job),
        .o_full  (full),
        .o_empty (q_empty)
    );

    irc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job             (q_job),
        .i_job_empty       (q_empty),
        .o_job_pop         (bk_pop),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_entry_is_burst  (o_entry_is_burst),
        .o_entry_width_us  (o_entry_width_us),
        .o_entry_index     (o_entry_index),
        .o_carrier_freq_hz (o_carrier_freq_hz),
        .o_carrier_valid   (o_carrier_valid),
        .o_last_entry      (o_last_entry)
    );

endmodule
`default_nettype wire

[test/ir_edge_capture_carrier_estimator_top_tb.sv]
// ----------------------------------------------------------------------------
// ir_edge_capture_carrier_estimator_top_tb
// Self-checking bench for the IR mark/space capture block. A queue of edge,
// clear and debounce requests feeds a clocked driver; an in-bench model of the
// capture state machine logs the entries each accepted edge should produce,
// and a clocked monitor pops results and compares them field by field.
// ----------------------------------------------------------------------------
module ir_edge_capture_carrier_estimator_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_ENTRIES  = 512;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 500;
    localparam int LIMIT        = 1000000;
    localparam int MAX_PRINTS   = 100;

    localparam logic MODE_EDGE  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        RQ_EDGE,
        RQ_CFG,
        RQ_DRAIN,
        RQ_HOLD,
        RQ_CALM
    } t_req_kind;

    typedef struct packed {
        t_req_kind                  kind;
        logic                       mode;
        logic [irc_pkg::TS_W-1:0]   ts;
        logic                       rise;
        logic                       fall;
        logic [irc_pkg::DBC_W-1:0]  arg;
    } t_req;

    typedef struct packed {
        logic                       burst;
        logic [irc_pkg::WID_W-1:0]  width;
        logic [irc_pkg::EIDX_W-1:0] idx;
        logic [irc_pkg::FREQ_W-1:0] freq;
        logic                       fvalid;
        logic                       last;
    } t_capture;

    logic                         i_clk;
    logic                         i_rst_n           = 1'b0;
    logic                         push              = 1'b0;
    logic                         full;
    logic                         i_mode            = 1'b0;
    logic [irc_pkg::TS_W-1:0]     i_time_us         = '0;
    logic                         i_rising          = 1'b0;
    logic                         i_falling         = 1'b0;
    logic                         empty;
    logic                         pop               = 1'b0;
    logic                         o_entry_is_burst;
    logic [irc_pkg::WID_W-1:0]    o_entry_width_us;
    logic [irc_pkg::EIDX_W-1:0]   o_entry_index;
    logic [irc_pkg::FREQ_W-1:0]   o_carrier_freq_hz;
    logic                         o_carrier_valid;
    logic                         o_last_entry;
    logic                         i_cfg_valid       = 1'b0;
    logic                         o_cfg_ready;
    logic [irc_pkg::DBC_W-1:0]    i_cfg_debounce_us = '0;

    t_req                         edge_reqs[$];
    t_req                         on_port;
    t_capture                     logged_entries[$];
    t_capture                     step_entries[$];

    // capture model state
    logic [irc_pkg::DBC_W-1:0]    debounce    = irc_pkg::DBC_RESET;
    irc_pkg::t_phase              ph          = irc_pkg::PH_RESET;
    logic [irc_pkg::TS_W-1:0]     last_edge   = '0;
    logic [irc_pkg::TS_W-1:0]     burst_t0    = '0;
    logic [irc_pkg::CNT_W-1:0]    pulses      = '0;
    logic [irc_pkg::CNT_W-1:0]    best_pulses = '0;
    logic [irc_pkg::FREQ_W-1:0]   freq_hz     = '0;
    logic                         freq_ok     = 1'b0;
    int                           next_idx    = 0;

    // stimulus generator state
    logic [irc_pkg::TS_W-1:0]     gen_t;
    int unsigned                  gen_dbc     = irc_pkg::DBC_RESET;

    logic                         calm        = 1'b0;
    logic                         hold_go     = 1'b0;
    int                           hold_left   = 0;
    int                           quiet_cycles = 0;
    int                           cycle_count = 0;
    int                           errors      = 0;

    ir_edge_capture_carrier_estimator_top #(
        .BUF_ENTRIES(BUF_ENTRIES)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_mode            (i_mode),
        .i_time_us         (i_time_us),
        .i_rising          (i_rising),
        .i_falling         (i_falling),
        .empty             (empty),
        .pop               (pop),
        .o_entry_is_burst  (o_entry_is_burst),
        .o_entry_width_us  (o_entry_width_us),
        .o_entry_index     (o_entry_index),
        .o_carrier_freq_hz (o_carrier_freq_hz),
        .o_carrier_valid   (o_carrier_valid),
        .o_last_entry      (o_last_entry),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_debounce_us (i_cfg_debounce_us)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic log_error(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("ERROR: %0t %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            log_error($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        end
    endtask

    task automatic log_entry(input logic burst, input logic [irc_pkg::TS_W-1:0] dur);
        t_capture c;
        if (next_idx >= BUF_ENTRIES) begin
            return;
        end
        c = '0;
        c.burst = burst;
        c.width = (dur > irc_pkg::TS_W'(irc_pkg::WID_MAX)) ? irc_pkg::WID_MAX
                                                           : dur[irc_pkg::WID_W-1:0];
        c.idx = irc_pkg::EIDX_W'(next_idx);
        next_idx++;
        step_entries.push_back(c);
    endtask

    task automatic classify_edge(input t_req rq);
        logic [irc_pkg::TS_W-1:0] gap;
        logic [irc_pkg::TS_W-1:0] dur;
        logic [63:0]              quot;
        step_entries.delete();
        if (rq.mode == MODE_CLEAR) begin
            ph = irc_pkg::PH_RESET;
            last_edge = '0;
            burst_t0 = '0;
            pulses = '0;
            best_pulses = '0;
            freq_hz = '0;
            freq_ok = 1'b0;
            next_idx = 0;
            return;
        end
        gap = rq.ts - last_edge;
        if (ph == irc_pkg::PH_RAW && gap > irc_pkg::TS_W'(debounce)) begin
            dur = last_edge - burst_t0;
            log_entry(1'b1, dur);
            if (best_pulses < pulses && dur != '0) begin
                quot = (64'(pulses) * 64'(irc_pkg::USEC_PER_SEC)) / 64'(dur);
                freq_hz = (quot > 64'(irc_pkg::FREQ_MAX)) ? irc_pkg::FREQ_MAX
                                                          : quot[irc_pkg::FREQ_W-1:0];
                freq_ok = 1'b1;
                best_pulses = pulses;
            end
            pulses = '0;
            ph = irc_pkg::PH_IDLE;
        end
        last_edge = rq.ts;
        if (ph == irc_pkg::PH_RESET) begin
            ph = irc_pkg::PH_IDLE;
            gap = '0;
        end
        case (ph)
            irc_pkg::PH_IDLE: begin
                if (rq.fall) begin
                    if (gap != '0) begin
                        log_entry(1'b0, gap);
                    end
                    ph = irc_pkg::PH_BURST;
                    burst_t0 = rq.ts;
                end
            end
            irc_pkg::PH_BURST: begin
                if (debounce != '0 && gap <= irc_pkg::TS_W'(debounce)) begin
                    ph = irc_pkg::PH_RAW;
                    if (rq.rise && pulses != irc_pkg::CNT_MAX) begin
                        pulses++;
                    end
                end else if (rq.rise) begin
                    log_entry(1'b1, gap);
                    ph = irc_pkg::PH_IDLE;
                    pulses = '0;
                end
            end
            default: begin
                if (rq.rise && pulses != irc_pkg::CNT_MAX) begin
                    pulses++;
                end
            end
        endcase
        foreach (step_entries[k]) begin
            step_entries[k].freq = freq_hz;
            step_entries[k].fvalid = freq_ok;
            step_entries[k].last = (k == step_entries.size() - 1);
            logged_entries.push_back(step_entries[k]);
        end
    endtask

    task automatic add_req(input t_req_kind kind, input logic mode,
                           input logic [irc_pkg::TS_W-1:0] ts, input logic rise,
                           input logic fall, input logic [irc_pkg::DBC_W-1:0] arg);
        t_req rq;
        rq.kind = kind;
        rq.mode = mode;
        rq.ts = ts;
        rq.rise = rise;
        rq.fall = fall;
        rq.arg = arg;
        edge_reqs.push_back(rq);
    endtask

    task automatic advance(input logic [irc_pkg::TS_W-1:0] gap, input logic rise,
                           input logic fall);
        gen_t = gen_t + gap;
        add_req(RQ_EDGE, MODE_EDGE, gen_t, rise, fall, '0);
    endtask

    task automatic add_clear();
        logic [63:0] r;
        r = {$urandom, $urandom};
        add_req(RQ_EDGE, MODE_CLEAR, r[irc_pkg::TS_W-1:0], r[48], r[49], '0);
    endtask

    task automatic add_cfg(input logic [irc_pkg::DBC_W-1:0] value);
        gen_dbc = value;
        add_req(RQ_CFG, MODE_EDGE, '0, 1'b0, 1'b0, value);
    endtask

    function automatic logic [irc_pkg::TS_W-1:0] long_gap();
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(19) == 0) begin
            return r[irc_pkg::TS_W-1:0];
        end
        return irc_pkg::TS_W'(gen_dbc) + irc_pkg::TS_W'($urandom_range(30000, 1));
    endfunction

    function automatic logic [irc_pkg::TS_W-1:0] short_gap();
        if ($urandom_range(7) == 0) begin
            return irc_pkg::TS_W'($urandom_range(gen_dbc));
        end
        return irc_pkg::TS_W'($urandom_range(gen_dbc < 40 ? gen_dbc : 40));
    endfunction

    // one space/mark frame, a raw carrier burst, a clear, or a few stray edges
    task automatic gen_frame(input bit allow_clear, input int unsigned raw_pct);
        int unsigned sel;
        int unsigned n;
        logic [63:0] r;
        sel = $urandom_range(99);
        if (allow_clear && sel < 2) begin
            add_clear();
        end else if (sel < 10) begin
            n = $urandom_range(4, 1);
            repeat (n) begin
                r = {$urandom, $urandom};
                if (r[63:62] == 2'b00) begin
                    gen_t = r[irc_pkg::TS_W-1:0];
                    add_req(RQ_EDGE, MODE_EDGE, gen_t, r[60], r[59], '0);
                end else begin
                    advance(irc_pkg::TS_W'(r[61:50]), r[60], r[59]);
                end
            end
        end else begin
            advance(long_gap(), $urandom_range(7) == 0, 1'b1);
            if (gen_dbc != 0 && $urandom_range(99) < raw_pct) begin
                n = $urandom_range(40, 1);
                repeat (n) begin
                    advance(short_gap(), 1'b1, $urandom_range(3) == 0);
                    advance(short_gap(), $urandom_range(3) == 0, 1'b1);
                end
            end else begin
                advance(long_gap(), 1'b1, $urandom_range(7) == 0);
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : drive
        t_req rq;
        logic nxt_push;
        logic nxt_cfg;
        logic nxt_hold;
        logic settled;
        if (!i_rst_n) begin
            push <= 1'b0;
            i_cfg_valid <= 1'b0;
            hold_go <= 1'b0;
        end else begin
            nxt_hold = 1'b0;
            if (push && !full) begin
                classify_edge(on_port);
                quiet_cycles = 0;
            end else if (logged_entries.size() != 0) begin
                quiet_cycles = 0;
            end else if (quiet_cycles < DRAIN_CYCLES) begin
                quiet_cycles++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                debounce = i_cfg_debounce_us;
            end
            settled = (logged_entries.size() == 0) && (quiet_cycles >= DRAIN_CYCLES);
            if (!(push && full) && !(i_cfg_valid && !o_cfg_ready)) begin
                nxt_push = 1'b0;
                nxt_cfg = 1'b0;
                if (edge_reqs.size() != 0) begin
                    case (edge_reqs[0].kind)
                        RQ_EDGE: begin
                            if (calm || $urandom_range(99) >= 25) begin
                                rq = edge_reqs.pop_front();
                                on_port = rq;
                                nxt_push = 1'b1;
                                i_mode <= rq.mode;
                                i_time_us <= rq.ts;
                                i_rising <= rq.rise;
                                i_falling <= rq.fall;
                            end
                        end
                        RQ_CFG: begin
                            if (settled) begin
                                rq = edge_reqs.pop_front();
                                nxt_cfg = 1'b1;
                                i_cfg_debounce_us <= rq.arg;
                            end
                        end
                        RQ_DRAIN: begin
                            if (settled) begin
                                rq = edge_reqs.pop_front();
                            end
                        end
                        RQ_HOLD: begin
                            rq = edge_reqs.pop_front();
                            nxt_hold = 1'b1;
                        end
                        default: begin
                            rq = edge_reqs.pop_front();
                            calm <= rq.arg[0];
                        end
                    endcase
                end
                push <= nxt_push;
                i_cfg_valid <= nxt_cfg;
            end
            hold_go <= nxt_hold;
        end
    end

    always @(posedge i_clk) begin : watch
        t_capture want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (logged_entries.size() == 0) begin
                    log_error($sformatf("entry %0d arrived with none outstanding",
                                        o_entry_index));
                end else begin
                    want = logged_entries.pop_front();
                    check_field("entry_is_burst", o_entry_is_burst, want.burst);
                    check_field("entry_width_us", o_entry_width_us, want.width);
                    check_field("entry_index", o_entry_index, want.idx);
                    check_field("carrier_freq_hz", o_carrier_freq_hz, want.freq);
                    check_field("carrier_valid", o_carrier_valid, want.fvalid);
                    check_field("last_entry", o_last_entry, want.last);
                end
            end
            pop <= (hold_left == 0) && (calm || $urandom_range(99) >= 25);
        end
    end

    initial begin
        int base;

        // directed: timestamps start just below the 48-bit wrap
        gen_t = 48'hFFFF_FFFF_FF00;
        advance('0, 1'b0, 1'b0);
        advance(48'd50000, 1'b0, 1'b1);
        advance(48'd600, 1'b1, 1'b0);
        advance(48'h0000_9000_0000, 1'b0, 1'b1);
        // zero-length raw burst
        advance('0, 1'b1, 1'b0);
        advance(48'd200, 1'b0, 1'b1);
        advance(48'd13, 1'b1, 1'b0);
        advance(48'd13, 1'b0, 1'b1);
        advance(48'd13, 1'b1, 1'b0);
        advance(48'd13, 1'b0, 1'b1);
        advance(48'd13, 1'b1, 1'b1);
        advance(48'd13, 1'b0, 1'b0);
        advance(48'd5000, 1'b0, 1'b1);
        // shorter burst, estimate kept
        advance(48'd10, 1'b1, 1'b0);
        advance(48'd10, 1'b0, 1'b1);
        advance(48'd3000, 1'b1, 1'b0);
        // timestamp going backwards
        advance(48'hFFFF_FFFF_FFFB, 1'b0, 1'b1);
        add_clear();
        advance(48'd123, 1'b0, 1'b1);
        advance(48'd40, 1'b1, 1'b0);
        advance(48'd40, 1'b1, 1'b1);
        advance(48'd40, 1'b0, 1'b0);

        // raw burst still open when filtering is switched off
        add_cfg('0);
        advance('0, 1'b1, 1'b0);
        advance(48'd7, 1'b0, 1'b1);
        advance(48'd5, 1'b1, 1'b0);
        advance('0, 1'b0, 1'b1);
        advance('0, 1'b1, 1'b0);
        base = edge_reqs.size();
        while (edge_reqs.size() - base < 70) gen_frame(1'b1, 40);

        add_cfg(16'hFFFF);
        gen_t = '0;
        advance('0, 1'b1, 1'b1);
        gen_t = '1;
        advance('0, 1'b0, 1'b1);
        base = edge_reqs.size();
        while (edge_reqs.size() - base < 70) gen_frame(1'b1, 40);

        add_cfg(16'd1);
        base = edge_reqs.size();
        while (edge_reqs.size() - base < 50) gen_frame(1'b1, 40);

        // buffer overflow, with the receiver held off at the start
        add_cfg(irc_pkg::DBC_RESET);
        add_clear();
        add_req(RQ_HOLD, MODE_EDGE, '0, 1'b0, 1'b0, '0);
        base = edge_reqs.size();
        while (edge_reqs.size() - base < 620) gen_frame(1'b0, 5);

        // long raw burst, no idling on either side
        add_req(RQ_CALM, MODE_EDGE, '0, 1'b0, 1'b0, 16'd1);
        add_clear();
        advance(48'd10, 1'b0, 1'b1);
        repeat (60) advance('0, 1'b1, $urandom_range(1));
        advance(48'd1, 1'b1, 1'b0);
        advance(48'd500, 1'b0, 1'b1);
        add_req(RQ_CALM, MODE_EDGE, '0, 1'b0, 1'b0, '0);
        add_clear();

        add_cfg(irc_pkg::DBC_W'($urandom_range(2000, 20)));
        base = edge_reqs.size();
        while (edge_reqs.size() - base < 180) gen_frame(1'b1, 40);
        add_req(RQ_DRAIN, MODE_EDGE, '0, 1'b0, 1'b0, '0);
        add_req(RQ_CALM, MODE_EDGE, '0, 1'b0, 1'b0, 16'd1);
        base = edge_reqs.size();
        while (edge_reqs.size() - base < 130) gen_frame(1'b1, 40);
        add_req(RQ_CALM, MODE_EDGE, '0, 1'b0, 1'b0, '0);
        add_cfg(irc_pkg::DBC_W'($urandom_range(65535)));
        base = edge_reqs.size();
        while (edge_reqs.size() - base < 150) gen_frame(1'b1, 40);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (edge_reqs.size() != 0 || push || i_cfg_valid) @(posedge i_clk);
        while (logged_entries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
